>>> src/jfp_pkg.sv
// shared constants, codes and types of the joystick frame parser
`timescale 1ns / 1ps

package jfp_pkg;

	localparam int BUTTON_COUNT = 6;
	localparam int FRAME_BYTES  = 6;
	localparam int RX_W         = 8;
	localparam int CHAR_W       = 7;
	localparam int POS_W        = 3;
	localparam int OUT_TDATA_W  = 32;

	localparam logic [RX_W-1:0]   SYM_STX   = 8'h02;
	localparam logic [RX_W-1:0]   SYM_ETX   = 8'h03;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
	localparam logic [POS_W-1:0]  POS_FIRST = 3'd1;
	localparam logic [POS_W-1:0]  POS_BTN   = 3'd2;
	localparam logic [POS_W-1:0]  POS_LAST  = 3'd7;

	localparam logic signed [15:0] DIGIT_ZERO  = 16'sd48;
	localparam logic signed [15:0] AXIS_OFFSET = 16'sd200;
	localparam logic signed [15:0] AXIS_LIMIT  = 16'sd100;

	typedef enum logic [1:0] {
		EV_BUTTON = 2'd0,
		EV_PADDLE = 2'd1,
		EV_ERROR  = 2'd2
	} event_kind_t;

	typedef struct packed {
		logic [5:0]        button_states;
		logic signed [7:0] y_position;
		logic signed [7:0] x_position;
		logic              button_down;
		logic [2:0]        button_index;
		event_kind_t       event_kind;
	} result_t;

endpackage

>>> src/jfp_axis_decode.sv
// decodes one paddle axis from three ascii digits and checks its range
`timescale 1ns / 1ps

module jfp_axis_decode
	import jfp_pkg::*;
(
	input  logic [CHAR_W-1:0] hundreds,
	input  logic [CHAR_W-1:0] tens,
	input  logic [CHAR_W-1:0] ones,
	output logic signed [7:0] axis_value,
	output logic              axis_ok
);

	logic signed [15:0] d_hundreds;
	logic signed [15:0] d_tens;
	logic signed [15:0] d_ones;
	logic signed [15:0] sum;

	assign d_hundreds = $signed(16'(hundreds)) - DIGIT_ZERO;
	assign d_tens     = $signed(16'(tens)) - DIGIT_ZERO;
	assign d_ones     = $signed(16'(ones)) - DIGIT_ZERO;

	assign sum = d_hundreds * 16'sd100 + d_tens * 16'sd10 + d_ones - AXIS_OFFSET;

	assign axis_value = sum[7:0];
	assign axis_ok    = (sum >= -AXIS_LIMIT) && (sum <= AXIS_LIMIT);

endmodule

>>> src/joystick_frame_parser_core.sv
// top level of the joystick frame parser: byte stream in, joystick events out
//
// s_axis carries received serial bytes, one per transaction, in tdata[7:0].
// m_axis carries one event per transaction, its kind in tuser and the event
// fields in tdata; bytes that end no frame, or end a button frame with an
// unknown letter, give no event.
// a byte enters an input register, is decoded against the frame state from
// there, and any event it ends is written to the output register. one byte
// per cycle is sustained while m_axis_tready is high; the frame state update
// is a single short step.
// while the output register holds an event that is not taken, the input
// register still takes one more byte, then s_axis_tready drops until the
// event leaves. nothing is lost or repeated under a stall.
// reset clears the frame state to idle, releases all buttons and empties both
// registers; stored frame characters are always rewritten before use.
`timescale 1ns / 1ps

module joystick_frame_parser_core
	import jfp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [RX_W-1:0]        s_axis_tdata,  // [7:0] rx_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [2:0] button_index, [3] button_down, [11:4] x_position,
	// [19:12] y_position, [25:20] button_states, rest zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]             m_axis_tuser   // [1:0] event_kind
);

	logic                    valid_s1;
	logic [RX_W-1:0]         byte_s1;
	logic                    advance;

	logic                    in_frame_q;
	logic [POS_W-1:0]        pos_q;
	logic [CHAR_W-1:0]       chars_q [FRAME_BYTES];
	logic [BUTTON_COUNT-1:0] flags_q;

	logic                    out_valid_q;
	result_t                 out_q;

	logic                    in_frame_d;
	logic [POS_W-1:0]        pos_d;
	logic [BUTTON_COUNT-1:0] flags_d;
	logic                    emit;
	result_t                 res;
	logic                    store;
	logic [POS_W-1:0]        pos_eff;
	logic [POS_W-1:0]        store_idx;

	logic [CHAR_W-1:0]       letter_off;
	logic                    letter_ok;
	logic [2:0]              btn_idx;
	logic                    btn_down;

	logic signed [7:0]       x_val;
	logic signed [7:0]       y_val;
	logic                    x_ok;
	logic                    y_ok;

	jfp_axis_decode u_axis_x (
		.hundreds   (chars_q[0]),
		.tens       (chars_q[1]),
		.ones       (chars_q[2]),
		.axis_value (x_val),
		.axis_ok    (x_ok)
	);

	jfp_axis_decode u_axis_y (
		.hundreds   (chars_q[3]),
		.tens       (chars_q[4]),
		.ones       (chars_q[5]),
		.axis_value (y_val),
		.axis_ok    (y_ok)
	);

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign letter_off = chars_q[0] - CHAR_A;
	assign letter_ok  = (chars_q[0] >= CHAR_A) &&
	                    (letter_off < CHAR_W'(2 * BUTTON_COUNT));
	assign btn_idx    = letter_off[3:1];
	assign btn_down   = !letter_off[0];

	assign pos_eff   = (pos_q == '0) ? POS_FIRST : pos_q;
	assign store_idx = pos_eff - POS_FIRST;

	always_comb begin
		in_frame_d = in_frame_q;
		pos_d      = pos_q;
		flags_d    = flags_q;
		emit       = 1'b0;
		store      = 1'b0;
		res        = '0;
		if (!in_frame_q) begin
			if (byte_s1 == SYM_STX) begin
				in_frame_d = 1'b1;
				pos_d      = POS_FIRST;
			end
		end else if (byte_s1[RX_W-1]) begin
			in_frame_d     = 1'b0;
			pos_d          = '0;
			emit           = 1'b1;
			res.event_kind = EV_ERROR;
		end else if (byte_s1 == SYM_ETX && pos_eff == POS_BTN) begin
			in_frame_d = 1'b0;
			pos_d      = '0;
			if (letter_ok) begin
				for (int i = 0; i < BUTTON_COUNT; i++) begin
					if (btn_idx == 3'(i)) begin
						flags_d[i] = btn_down;
					end
				end
				emit             = 1'b1;
				res.event_kind   = EV_BUTTON;
				res.button_index = btn_idx;
				res.button_down  = btn_down;
			end
		end else if (pos_eff == POS_LAST) begin
			in_frame_d = 1'b0;
			pos_d      = '0;
			emit       = 1'b1;
			if (byte_s1 == SYM_ETX && x_ok && y_ok) begin
				res.event_kind = EV_PADDLE;
				res.x_position = x_val;
				res.y_position = y_val;
			end else begin
				res.event_kind = EV_ERROR;
			end
		end else begin
			store = 1'b1;
			pos_d = pos_eff + POS_FIRST;
		end
		res.button_states = 6'(flags_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				in_frame_q <= in_frame_d;
				pos_q      <= pos_d;
				flags_q    <= flags_d;
			end
			if (advance) begin
				out_valid_q <= emit;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && store) begin
			chars_q[store_idx] <= byte_s1[CHAR_W-1:0];
		end
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.event_kind;
	assign m_axis_tdata  = OUT_TDATA_W'({out_q.button_states, out_q.y_position,
	                                     out_q.x_position, out_q.button_down,
	                                     out_q.button_index});

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench of the joystick frame parser core
`timescale 1ns / 1ps

module testbench;

	import jfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int SENDER         = 0;
	localparam int RECEIVER       = 1;
	localparam int DATA_W         = $bits(result_t) - 2;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [RX_W-1:0]        s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;

	logic [RX_W-1:0] tx_bytes[$];
	result_t         pending_events[$];
	result_t         rx_event;
	result_t         want;
	result_t         got;

	// parser state as predicted from the accepted bytes
	logic                    in_frame  = 1'b0;
	logic [POS_W-1:0]        frame_pos = '0;
	logic [CHAR_W-1:0]       frame_chars[FRAME_BYTES];
	logic [BUTTON_COUNT-1:0] pressed   = '0;

	int calm_left[2];
	int send_stall;
	int recv_stall;
	int n_events;
	int quiet_cycles;
	int fail_count;
	bit long_hold_done;

	joystick_frame_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int pick_pause(input int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4)
			calm_left[side] = $urandom_range(20, 80);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int axis_of(input int first);
		int d0, d1, d2;
		d0 = int'(frame_chars[first]) - DIGIT_ZERO;
		d1 = int'(frame_chars[first + 1]) - DIGIT_ZERO;
		d2 = int'(frame_chars[first + 2]) - DIGIT_ZERO;
		return d0 * 100 + d1 * 10 + d2 - AXIS_OFFSET;
	endfunction

	function automatic bit decode_rx_byte(input logic [RX_W-1:0] rx, output result_t ev);
		logic [POS_W-1:0] pos;
		int off, x, y, lim;
		ev = '0;
		lim = AXIS_LIMIT;
		if (!in_frame) begin
			if (rx == SYM_STX) begin
				in_frame  = 1'b1;
				frame_pos = POS_FIRST;
			end
			return 1'b0;
		end
		pos = (frame_pos == '0) ? POS_FIRST : frame_pos;
		if (rx[RX_W-1]) begin
			in_frame         = 1'b0;
			frame_pos        = '0;
			ev.event_kind    = EV_ERROR;
			ev.button_states = pressed;
			return 1'b1;
		end
		if (rx == SYM_ETX && pos == POS_BTN) begin
			in_frame  = 1'b0;
			frame_pos = '0;
			off = int'(frame_chars[0]) - int'(CHAR_A);
			if (off < 0 || off >= 2 * BUTTON_COUNT)
				return 1'b0;
			pressed[off / 2]  = (off % 2 == 0);
			ev.event_kind     = EV_BUTTON;
			ev.button_index   = 3'(off / 2);
			ev.button_down    = (off % 2 == 0);
			ev.button_states  = pressed;
			return 1'b1;
		end
		if (pos == POS_LAST) begin
			in_frame         = 1'b0;
			frame_pos        = '0;
			ev.event_kind    = EV_ERROR;
			ev.button_states = pressed;
			if (rx == SYM_ETX) begin
				x = axis_of(0);
				y = axis_of(3);
				if (x >= -lim && x <= lim && y >= -lim && y <= lim) begin
					ev.event_kind = EV_PADDLE;
					ev.x_position = 8'(x);
					ev.y_position = 8'(y);
				end
			end
			return 1'b1;
		end
		frame_chars[pos - 3'd1] = rx[CHAR_W-1:0];
		frame_pos = pos + 3'd1;
		return 1'b0;
	endfunction

	task automatic push_byte(input logic [RX_W-1:0] b);
		tx_bytes.push_back(b);
	endtask

	task automatic push_frame(input string body, input logic [RX_W-1:0] tail);
		push_byte(SYM_STX);
		for (int i = 0; i < body.len(); i++)
			push_byte(body[i]);
		push_byte(tail);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] exp_val,
			input logic signed [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
			fail_count++;
		end
	endtask

	// sender: one byte per transaction, random gaps between bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_rx_byte(s_axis_tdata, rx_event))
					pending_events.push_back(rx_event);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_stall > 0) begin
					send_stall--;
					s_axis_tvalid <= 1'b0;
				end else if (tx_bytes.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= tx_bytes.pop_front();
					send_stall = pick_pause(SENDER);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off while bytes keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_events++;
				recv_stall = pick_pause(RECEIVER);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			if (!long_hold_done && n_events >= 40) begin
				long_hold_done = 1'b1;
				recv_stall = LONG_HOLD;
			end
			m_axis_tready <= (recv_stall == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'({m_axis_tdata[DATA_W-1:0], m_axis_tuser});
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual tdata %h", $time,
					m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				check_field("event_kind", want.event_kind, got.event_kind);
				check_field("button_index", want.button_index, got.button_index);
				check_field("button_down", want.button_down, got.button_down);
				check_field("x_position", want.x_position, got.x_position);
				check_field("y_position", want.y_position, got.y_position);
				check_field("button_states", want.button_states, got.button_states);
				check_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:DATA_W]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("%0t: timeout", $time);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int pick, xo, yo, n;
		logic [RX_W-1:0] letter;
		string body;

		// idle noise, every button letter edge, paddle extremes and each broken frame
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(SYM_ETX);
		push_frame("A", SYM_ETX);
		push_frame("L", SYM_ETX);
		push_frame("K", SYM_ETX);
		push_frame("B", SYM_ETX);
		push_frame("M", SYM_ETX);
		push_frame("a", SYM_ETX);
		push_frame("300100", SYM_ETX);
		push_frame("100300", SYM_ETX);
		push_frame("200200", SYM_ETX);
		push_frame("099200", SYM_ETX);
		push_frame("200301", SYM_ETX);
		push_frame("2:0200", SYM_ETX);
		push_frame("C", 8'h80);
		push_frame("12", 8'hFF);
		push_frame("123456", "7");
		push_frame("\002", SYM_ETX);
		push_frame("\003", SYM_ETX);
		push_frame("20\003\003\003\003", SYM_ETX);

		while (tx_bytes.size() < 600) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				if ($urandom_range(0, 9) < 9)
					letter = 8'(CHAR_A) + 8'($urandom_range(0, 2 * BUTTON_COUNT - 1));
				else
					letter = 8'($urandom_range(0, 127));
				push_byte(SYM_STX);
				push_byte(letter);
				push_byte(SYM_ETX);
			end else if (pick < 75) begin
				xo = $urandom_range(100, 300);
				yo = $urandom_range(100, 300);
				if ($urandom_range(0, 99) < 15)
					xo = $urandom_range(0, 999);
				if ($urandom_range(0, 99) < 15)
					yo = $urandom_range(0, 999);
				body = $sformatf("%03d%03d", xo, yo);
				if ($urandom_range(0, 9) == 0)
					body[$urandom_range(0, 5)] = 8'($urandom_range(1, 127));
				push_frame(body, SYM_ETX);
			end else if (pick < 85) begin
				push_byte(SYM_STX);
				n = $urandom_range(0, 8);
				repeat (n) push_byte(8'($urandom_range(0, 255)));
			end else if (pick < 92) begin
				push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_byte(SYM_STX);
				n = $urandom_range(0, 6);
				repeat (n) push_byte(8'($urandom_range(48, 57)));
				push_byte(8'($urandom_range(128, 255)));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || s_axis_tvalid || pending_events.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (fail_count == 0 && pending_events.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
